[design/c2pd_pkg.sv]
package c2pd_pkg;

  // Defaults for the top-level parameters.
  localparam int COORD_BITS_DEF     = 16;
  localparam int ROTATION_STEPS_DEF = 16;

  // Fraction bits carried by the working x and y.
  localparam int FRAC_BITS = 16;

  // Angle accumulator width (degrees times 2^16, total swing under 100 degrees).
  localparam int ZW = 25;

  // Result field widths.
  localparam int MAG_W = 16;
  localparam int ANG_W = 17;

  // CORDIC gain correction, 0.607252935 times 2^32.
  localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;

  // Angles in 1/128 degree.
  localparam logic signed [ANG_W-1:0] DEG90_UNITS  = 17'sd11520;
  localparam logic signed [ANG_W-1:0] DEG180_UNITS = 17'sd23040;

  // Rounding offset and shift from degrees times 2^16 to 1/128 degree.
  localparam logic signed [ZW-1:0] ANG_ROUND = 25'sd256;
  localparam int ANG_SHIFT = 9;

  localparam int ATAN_LEN = 32;

  // atan(2^-i) in degrees times 2^16.
  localparam logic signed [ZW-1:0] ATAN_TABLE [ATAN_LEN] = '{
    25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
    25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
    25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
    25'sd917,     25'sd458,     25'sd229,    25'sd115,
    25'sd57,      25'sd29,      25'sd14,     25'sd7,
    25'sd4,       25'sd2,       25'sd1,      25'sd0,
    25'sd0,       25'sd0,       25'sd0,      25'sd0,
    25'sd0,       25'sd0,       25'sd0,      25'sd0
  };

  // Facts about an item that ride along the rotation pipeline.
  typedef struct packed {
    logic                    origin;   // both coordinates zero
    logic                    axis;     // exact result, rotation output ignored
    logic                    flip;     // point was turned by 180 degrees
    logic [MAG_W-1:0]        axis_mag;
    logic signed [ANG_W-1:0] axis_ang;
  } side_t;

endpackage

[design/cartesian_to_polar_degrees_core.sv]
// Cartesian to polar conversion in degrees, CORDIC vectoring pipeline.
// Input channel: in_valid / in_stall carry one point (x_coord, y_coord) per
// transaction, taken at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry magnitude, angle_deg (1/128
// degree, -90 to 270 degrees) and undefined_angle, which is set only at the
// origin, where the angle reads as zero.
// The pipeline has one input stage, one stage per micro-rotation, one gain
// multiply stage and one output stage. A new transaction may enter every
// cycle while in_stall is low, so throughput is one result per cycle while
// the receiver does not stall; every stage holds its own valid bit.
// When the receiver stalls, each stage keeps advancing until it reaches a
// full stage ahead of it, so bubbles are squeezed out; in_stall rises only
// when every stage holds an item. Nothing is lost or repeated.
// Reset clears all valid bits; the block keeps no other state.
module cartesian_to_polar_degrees_core #(
  parameter int COORD_BITS     = c2pd_pkg::COORD_BITS_DEF,
  parameter int ROTATION_STEPS = c2pd_pkg::ROTATION_STEPS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [COORD_BITS-1:0]          x_coord,
  input  logic signed [COORD_BITS-1:0]          y_coord,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [c2pd_pkg::MAG_W-1:0]            magnitude,
  output logic signed [c2pd_pkg::ANG_W-1:0]     angle_deg,
  output logic                                  undefined_angle
);

  // Working width: the turned input plus fraction bits, with room for the
  // CORDIC gain and the diagonal growth.
  localparam int W  = COORD_BITS + c2pd_pkg::FRAC_BITS + 3;
  // Gain product is split at bit 32 into two partial products.
  localparam int PW = (W > 32) ? W : 33;
  localparam int MW = PW - 15;

  // ---------------------------------------------------------------------
  // Input stage: classify the point, turn it into the right half plane.
  // ---------------------------------------------------------------------
  logic                   prep_valid;
  logic                   prep_ready;
  logic signed [W-1:0]    xe;
  logic signed [W-1:0]    ye;
  logic signed [W-1:0]    ax;
  logic signed [W-1:0]    ay;
  logic signed [W-1:0]    cx_base;
  logic signed [W-1:0]    cy_base;
  c2pd_pkg::side_t        side_next;

  logic signed [W-1:0]            rot_x     [ROTATION_STEPS+1];
  logic signed [W-1:0]            rot_y     [ROTATION_STEPS+1];
  logic signed [c2pd_pkg::ZW-1:0] rot_z     [ROTATION_STEPS+1];
  c2pd_pkg::side_t                rot_side  [ROTATION_STEPS+1];
  logic                           rot_valid [ROTATION_STEPS+1];
  logic                           rot_ready [ROTATION_STEPS+1];

  always_comb begin
    xe = W'(x_coord);
    ye = W'(y_coord);
    ax = (xe < 0) ? -xe : xe;
    ay = (ye < 0) ? -ye : ye;
    cx_base = (xe < 0) ? -xe : xe;
    cy_base = (xe < 0) ? -ye : ye;

    side_next.origin   = (xe == '0) && (ye == '0);
    side_next.axis     = (xe == '0) || (ye == '0);
    side_next.flip     = (xe < 0);
    side_next.axis_mag = '0;
    side_next.axis_ang = '0;
    if (side_next.origin) begin
      side_next.axis_mag = '0;
      side_next.axis_ang = '0;
    end else if (ye == '0) begin
      side_next.axis_mag = ax[c2pd_pkg::MAG_W-1:0];
      side_next.axis_ang = (xe < 0) ? c2pd_pkg::DEG180_UNITS : '0;
    end else if (xe == '0) begin
      side_next.axis_mag = ay[c2pd_pkg::MAG_W-1:0];
      side_next.axis_ang = (ye < 0) ? -c2pd_pkg::DEG90_UNITS : c2pd_pkg::DEG90_UNITS;
    end
  end

  assign prep_ready = !prep_valid || rot_ready[0];
  assign in_stall   = !prep_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_valid <= 1'b0;
    end else if (prep_ready) begin
      prep_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prep_ready && in_valid) begin
      rot_x[0]    <= cx_base <<< c2pd_pkg::FRAC_BITS;
      rot_y[0]    <= cy_base <<< c2pd_pkg::FRAC_BITS;
      rot_z[0]    <= '0;
      rot_side[0] <= side_next;
    end
  end

  assign rot_valid[0] = prep_valid;

  // ---------------------------------------------------------------------
  // Micro-rotation stages, one register stage each.
  // ---------------------------------------------------------------------
  for (genvar k = 0; k < ROTATION_STEPS; k++) begin : g_rot
    c2pd_rot_stage #(
      .W    (W),
      .STEP (k)
    ) u_stage (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (rot_valid[k]),
      .up_ready   (rot_ready[k]),
      .x_in       (rot_x[k]),
      .y_in       (rot_y[k]),
      .z_in       (rot_z[k]),
      .side_in    (rot_side[k]),
      .valid      (rot_valid[k+1]),
      .down_ready (rot_ready[k+1]),
      .x          (rot_x[k+1]),
      .y          (rot_y[k+1]),
      .z          (rot_z[k+1]),
      .side       (rot_side[k+1])
    );
  end

  // ---------------------------------------------------------------------
  // Gain stage: two partial products of x times the gain correction, and
  // the angle rounded, clamped to +-90 degrees and unfolded.
  // ---------------------------------------------------------------------
  logic                              prod_valid;
  logic                              prod_ready;
  logic [PW-1:0]                     ux;
  logic [63:0]                       lo_next;
  logic [PW-1:0]                     hi_next;
  logic signed [c2pd_pkg::ZW-1:0]    zr;
  logic signed [c2pd_pkg::ZW-1:0]    zc;
  logic signed [c2pd_pkg::ANG_W-1:0] ang_next;
  logic [63:0]                       prod_lo;
  logic [PW-1:0]                     prod_hi;
  logic signed [c2pd_pkg::ANG_W-1:0] prod_ang;
  c2pd_pkg::side_t                   prod_side;
  logic                              out_ready;

  always_comb begin
    ux      = (rot_x[ROTATION_STEPS] < 0) ? '0 : PW'(rot_x[ROTATION_STEPS]);
    lo_next = 64'(ux[31:0]) * 64'(c2pd_pkg::GAIN_Q32);
    hi_next = PW'(ux[PW-1:32]) * PW'(c2pd_pkg::GAIN_Q32);

    zr = (rot_z[ROTATION_STEPS] + c2pd_pkg::ANG_ROUND) >>> c2pd_pkg::ANG_SHIFT;
    if (zr > c2pd_pkg::ZW'(c2pd_pkg::DEG90_UNITS)) begin
      zc = c2pd_pkg::ZW'(c2pd_pkg::DEG90_UNITS);
    end else if (zr < -c2pd_pkg::ZW'(c2pd_pkg::DEG90_UNITS)) begin
      zc = -c2pd_pkg::ZW'(c2pd_pkg::DEG90_UNITS);
    end else begin
      zc = zr;
    end
    ang_next = c2pd_pkg::ANG_W'(zc)
             + (rot_side[ROTATION_STEPS].flip ? c2pd_pkg::DEG180_UNITS : '0);
  end

  assign prod_ready = !prod_valid || out_ready;
  assign rot_ready[ROTATION_STEPS] = prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_ready) begin
      prod_valid <= rot_valid[ROTATION_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && rot_valid[ROTATION_STEPS]) begin
      prod_lo   <= lo_next;
      prod_hi   <= hi_next;
      prod_ang  <= ang_next;
      prod_side <= rot_side[ROTATION_STEPS];
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: sum the partial products, round, saturate, and pick the
  // exact result for points on an axis.
  // ---------------------------------------------------------------------
  logic [PW:0]                 prod_sum;
  logic [MW-1:0]               mag_full;
  logic [MW-1:0]               mag_sat;
  logic [c2pd_pkg::MAG_W-1:0]  mag_next;

  always_comb begin
    prod_sum = (PW+1)'(prod_hi) + (PW+1)'(prod_lo[63:32])
             + (PW+1)'(1 << (c2pd_pkg::FRAC_BITS - 1));
    mag_full = prod_sum[PW:c2pd_pkg::FRAC_BITS];
    if (|mag_full[MW-1:COORD_BITS]) begin
      mag_sat = (MW'(1) << COORD_BITS) - MW'(1);
    end else begin
      mag_sat = mag_full;
    end
    mag_next = prod_side.axis ? prod_side.axis_mag : mag_sat[c2pd_pkg::MAG_W-1:0];
  end

  assign out_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && prod_valid) begin
      magnitude       <= mag_next;
      angle_deg       <= prod_side.axis ? prod_side.axis_ang : prod_ang;
      undefined_angle <= prod_side.origin;
    end
  end

  // ---------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------

  // The input side only stalls when the output side is stalled.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_stall)
    else $error("input stalled while output was not stalled");

  // The origin flag always comes with a zero result.
  a_origin_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && undefined_angle) |-> (magnitude == '0 && angle_deg == '0))
    else $error("origin result is not zero");

  // The angle stays within -90 to 270 degrees.
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (angle_deg >= -c2pd_pkg::DEG90_UNITS
                   && angle_deg <= c2pd_pkg::DEG180_UNITS + c2pd_pkg::DEG90_UNITS))
    else $error("angle out of range");

  // A result taken with the pipeline stage behind it full is replaced next cycle.
  a_refill: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && prod_valid) |=> out_valid)
    else $error("pipeline lost an item on the way to the output");

endmodule

[design/c2pd_rot_stage.sv]
// One CORDIC vectoring micro-rotation with its own pipeline register.
module c2pd_rot_stage #(
  parameter int W    = 35,
  parameter int STEP = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  logic signed [W-1:0]               x_in,
  input  logic signed [W-1:0]               y_in,
  input  logic signed [c2pd_pkg::ZW-1:0]    z_in,
  input  c2pd_pkg::side_t                   side_in,
  output logic                              valid,
  input  logic                              down_ready,
  output logic signed [W-1:0]               x,
  output logic signed [W-1:0]               y,
  output logic signed [c2pd_pkg::ZW-1:0]    z,
  output c2pd_pkg::side_t                   side
);

  logic signed [W-1:0]            dx;
  logic signed [W-1:0]            dy;
  logic signed [W-1:0]            x_next;
  logic signed [W-1:0]            y_next;
  logic signed [c2pd_pkg::ZW-1:0] z_next;

  assign up_ready = !valid || down_ready;

  // Turn toward the x axis: the sign of y picks the direction.
  always_comb begin
    dx = y_in >>> STEP;
    dy = x_in >>> STEP;
    if (y_in < 0) begin
      x_next = x_in - dx;
      y_next = y_in + dy;
      z_next = z_in - c2pd_pkg::ATAN_TABLE[STEP];
    end else begin
      x_next = x_in + dx;
      y_next = y_in - dy;
      z_next = z_in + c2pd_pkg::ATAN_TABLE[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      x    <= x_next;
      y    <= y_next;
      z    <= z_next;
      side <= side_in;
    end
  end

endmodule
